// ===== rtl/pcle_pkg.sv =====
// Package for the positional circular list engine: command and status codes.
// Used by the controller, the datapath and the top level.
`default_nettype none
package pcle_pkg;

  localparam int unsigned CmdWidth = 3;
  localparam int unsigned PosWidth = 8;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [CmdWidth-1:0] {
    CmdInsHead = 3'd0,
    CmdInsTail = 3'd1,
    CmdInsAt   = 3'd2,
    CmdDelHead = 3'd3,
    CmdDelTail = 3'd4,
    CmdDelAt   = 3'd5,
    CmdDump    = 3'd6,
    CmdCount   = 3'd7
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StBadPos = 2'd2,
    StFull  = 2'd3
  } status_e;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OpNone    = 3'd0,
    OpLoad    = 3'd1,
    OpWalkHd  = 3'd2,
    OpStep    = 3'd3,
    OpAddEnd  = 3'd4,
    OpAddAft  = 3'd5,
    OpRemove  = 3'd6
  } op_e;

  typedef struct packed {
    op_e  op;
    logic at_head;   // add at head (vs tail)
    logic rm_tail;   // remove tail (vs cursor/head)
    logic rm_head;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/pcle_datapath.sv =====
// Datapath of the list engine: entry store, links, free map, head, tail, count
// and a walking cursor. Depends on pcle_pkg.
`default_nettype none
module pcle_datapath #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pcle_pkg::dp_cmd_t     cmd_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  output logic [CntW-1:0]            count_o,
  output logic [DATA_WIDTH-1:0]      cur_value_o
);
  import pcle_pkg::*;

  logic [DATA_WIDTH-1:0] values_q [CAPACITY];
  logic [IdxW-1:0] next_q [CAPACITY];
  logic [IdxW-1:0] prev_q [CAPACITY];
  logic [CAPACITY-1:0] free_q;
  logic [IdxW-1:0] head_q, tail_q, cur_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] slot;
  logic [IdxW-1:0] rm;

  // Lowest free slot; defaults to the last slot when none is free.
  always_comb begin
    slot = IdxW'(CAPACITY - 1);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) slot = IdxW'(i);
    end
  end

  always_comb begin
    if (cmd_i.rm_tail) rm = tail_q;
    else if (cmd_i.rm_head) rm = head_q;
    else rm = cur_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpAddEnd: begin
        values_q[slot] <= value_i;
        if (count_q == '0) begin
          next_q[slot] <= slot;
          prev_q[slot] <= slot;
        end else begin
          next_q[slot] <= head_q;
          prev_q[slot] <= tail_q;
          prev_q[head_q] <= slot;
          next_q[tail_q] <= slot;
        end
      end
      OpAddAft: begin
        values_q[slot] <= value_i;
        next_q[slot] <= next_q[cur_q];
        prev_q[slot] <= cur_q;
        prev_q[next_q[cur_q]] <= slot;
        next_q[cur_q] <= slot;
      end
      OpRemove: begin
        if (count_q > CntW'(1)) begin
          next_q[prev_q[rm]] <= next_q[rm];
          prev_q[next_q[rm]] <= prev_q[rm];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      head_q <= '0;
      tail_q <= '0;
      count_q <= '0;
      cur_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpWalkHd: cur_q <= head_q;
        OpStep:   cur_q <= next_q[cur_q];
        OpAddEnd: begin
          free_q[slot] <= 1'b0;
          count_q <= count_q + CntW'(1);
          if (count_q == '0) begin
            head_q <= slot;
            tail_q <= slot;
          end else if (cmd_i.at_head) begin
            head_q <= slot;
          end else begin
            tail_q <= slot;
          end
        end
        OpAddAft: begin
          free_q[slot] <= 1'b0;
          count_q <= count_q + CntW'(1);
        end
        OpRemove: begin
          free_q[rm] <= 1'b1;
          if (count_q <= CntW'(1)) begin
            count_q <= '0;
            head_q <= '0;
            tail_q <= '0;
          end else begin
            count_q <= count_q - CntW'(1);
            if (rm == head_q) head_q <= next_q[rm];
            if (rm == tail_q) tail_q <= prev_q[rm];
          end
        end
        default: ;
      endcase
    end
  end

  assign count_o = count_q;
  assign cur_value_o = values_q[cur_q];

endmodule
`default_nettype wire

// ===== rtl/pcle_ctrl.sv =====
// Controller of the list engine: decodes a command word, sequences the walk
// and emits result words. Depends on pcle_pkg.
`default_nettype none
module pcle_ctrl #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pcle_pkg::CmdWidth-1:0] cmd_i,
  input  wire logic [pcle_pkg::PosWidth-1:0] pos_i,
  input  wire logic [CntW-1:0]               count_i,
  output pcle_pkg::dp_cmd_t                  dp_cmd_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [pcle_pkg::StatusWidth-1:0]   res_status_o,
  output logic                               res_elem_o,
  output logic                               res_last_o
);
  import pcle_pkg::*;

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SWalk = 4'b0010,
    SExec = 4'b0100,
    SOut  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cmd_e cmd_q, cmd_d;
  logic [PosWidth-1:0] steps_q, steps_d;
  logic [StatusWidth-1:0] st_q, st_d;
  logic [CntW-1:0] left_q, left_d;
  logic dump_q, dump_d;
  logic [PosWidth:0] cnt_ext;

  // Remember the end cases of a positional insert at decode time.
  logic pos_one_q, pos_end_q;
  logic pos_q_is_one, pos_q_is_end;
  assign pos_q_is_one = pos_one_q;
  assign pos_q_is_end = pos_end_q;

  assign cnt_ext = (PosWidth + 1)'(count_i);
  assign in_ready_o = (state_q == SIdle);
  assign res_valid_o = (state_q == SOut);
  assign res_status_o = st_q;
  assign res_elem_o = dump_q;
  assign res_last_o = !dump_q || (left_q == CntW'(1));

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    steps_d = steps_q;
    st_d = st_q;
    left_d = left_q;
    dump_d = dump_q;
    dp_cmd_o = '{op: OpNone, at_head: 1'b0, rm_tail: 1'b0, rm_head: 1'b0};
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_d = cmd_e'(cmd_i);
          st_d = StOk;
          dump_d = 1'b0;
          state_d = SOut;
          dp_cmd_o.op = OpWalkHd;
          unique case (cmd_e'(cmd_i))
            CmdInsHead, CmdInsTail: begin
              if (count_i >= CntW'(CAPACITY)) st_d = StFull;
              else state_d = SExec;
            end
            CmdInsAt: begin
              if (pos_i == '0 || {1'b0, pos_i} > cnt_ext + 1'b1) st_d = StBadPos;
              else if (count_i >= CntW'(CAPACITY)) st_d = StFull;
              else begin
                steps_d = (pos_i < 8'd2) ? '0 : pos_i - 8'd2;
                state_d = SWalk;
              end
            end
            CmdDelHead, CmdDelTail: begin
              if (count_i == '0) st_d = StEmpty;
              else state_d = SExec;
            end
            CmdDelAt: begin
              if (pos_i == '0 || {1'b0, pos_i} > cnt_ext) st_d = StBadPos;
              else begin
                steps_d = pos_i - 8'd1;
                state_d = SWalk;
              end
            end
            CmdDump: begin
              if (count_i == '0) st_d = StEmpty;
              else begin
                dump_d = 1'b1;
                left_d = count_i;
              end
            end
            CmdCount: begin
              if (count_i == '0) st_d = StEmpty;
            end
            default: ;
          endcase
        end
      end
      SWalk: begin
        if (steps_q == '0) state_d = SExec;
        else begin
          dp_cmd_o.op = OpStep;
          steps_d = steps_q - 8'd1;
        end
      end
      SExec: begin
        state_d = SOut;
        unique case (cmd_q)
          CmdInsHead: begin
            dp_cmd_o.op = OpAddEnd;
            dp_cmd_o.at_head = 1'b1;
          end
          CmdInsTail: dp_cmd_o.op = OpAddEnd;
          CmdInsAt: begin
            // First and one-past-last positions act as end inserts.
            if (pos_q_is_one) begin
              dp_cmd_o.op = OpAddEnd;
              dp_cmd_o.at_head = 1'b1;
            end else if (pos_q_is_end) dp_cmd_o.op = OpAddEnd;
            else dp_cmd_o.op = OpAddAft;
          end
          CmdDelHead: begin
            dp_cmd_o.op = OpRemove;
            dp_cmd_o.rm_head = 1'b1;
          end
          CmdDelTail: begin
            dp_cmd_o.op = OpRemove;
            dp_cmd_o.rm_tail = 1'b1;
          end
          CmdDelAt: dp_cmd_o.op = OpRemove;
          default: ;
        endcase
      end
      SOut: begin
        if (res_ready_i) begin
          if (dump_q && left_q != CntW'(1)) begin
            left_d = left_q - CntW'(1);
            dp_cmd_o.op = OpStep;
          end else state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cmd_q <= CmdCount;
      steps_q <= '0;
      st_q <= StOk;
      left_q <= '0;
      dump_q <= 1'b0;
      pos_one_q <= 1'b0;
      pos_end_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q <= cmd_d;
      steps_q <= steps_d;
      st_q <= st_d;
      left_q <= left_d;
      dump_q <= dump_d;
      if (state_q == SIdle && in_valid_i) begin
        pos_one_q <= (pos_i == 8'd1);
        pos_end_q <= ({1'b0, pos_i} == cnt_ext + 1'b1);
      end
    end
  end

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SWalk && steps_q == '0 |=> state_q == SExec)
    else $error("walk did not hand over to execute");
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SExec |=> state_q == SOut)
    else $error("execute did not produce a result");
  a_dump_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SOut && dump_q |-> left_q != '0)
    else $error("dump with no elements left");

endmodule
`default_nettype wire

// ===== rtl/positional_circular_list_engine.sv =====
// Top level of the positional circular list engine: stream ports, controller
// and datapath. Depends on pcle_pkg, pcle_ctrl and pcle_datapath.
// Path to the first result word: count, dump and rejected commands go from
// idle straight to output, head or tail updates pass through execute, and
// positional ones walk up to CAPACITY-1 links first. Dump words step the cursor.
// Throughput: one command at a time; the next word is taken the cycle after
// the last result word leaves, so the link walk and output back-pressure set the rate.
// Reset: asynchronous, active low; clears the free map, head, tail and count.
`default_nettype none
module positional_circular_list_engine #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: cmd[2:0], value[34:3], position[42:35], zero pad to 48
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[1:0], element[33:2], element_count[38:34], zero pad to 40
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import pcle_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  dp_cmd_t dp_cmd;
  logic [CntW-1:0] count;
  logic [DATA_WIDTH-1:0] cur_value;
  logic [StatusWidth-1:0] status;
  logic elem_sel;
  logic [31:0] element;

  pcle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tdata[2:0]),
    .pos_i       (s_axis_tdata[42:35]),
    .count_i     (count),
    .dp_cmd_o    (dp_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_status_o(status),
    .res_elem_o  (elem_sel),
    .res_last_o  (m_axis_tlast)
  );

  // Value is captured when written into the store during execute; the input
  // word is held by the controller only as a command, so latch the value.
  logic [DATA_WIDTH-1:0] value_q;
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) value_q <= DATA_WIDTH'(s_axis_tdata[34:3]);
  end

  pcle_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (dp_cmd),
    .value_i    (value_q),
    .count_o    (count),
    .cur_value_o(cur_value)
  );

  // Sign-extend or truncate the stored value to the 32-bit element field; zero when no element is sent.
  always_comb begin
    if (elem_sel) element = 32'($signed(cur_value));
    else element = '0;
  end

  assign m_axis_tdata = {1'b0, 5'(count), element, status};

endmodule
`default_nettype wire
